// ----- design/real_to_radix_digit_string_core_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef REAL_TO_RADIX_DIGIT_STRING_CORE_ASSERT_SVH
`define REAL_TO_RADIX_DIGIT_STRING_CORE_ASSERT_SVH

// General form: explicit clock and active-low reset.
`define RRDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rrds assertion failed");

// Short form on the block clock and reset.
`define RRDS_ASSERT_CLK(lbl, prop) \
  `RRDS_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ----- design/rrds_pkg.sv -----
// ---------------------------------------------------------------------------
// rrds_pkg: shared types and constants of the radix digit string block
// Field widths, character codes, register indexes and the digit encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rrds_pkg;

  // Field and register widths
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 6;
  localparam int MAXFD_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Default fixed-point format
  localparam int FRAC_BITS_DEF = 32;
  localparam int INT_BITS_DEF  = 31;

  // Digit buffer
  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = 5;
  localparam int LEN_W     = 6;

  // Register limits and reset values
  localparam logic [RADIX_W-1:0] RADIX_MIN       = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX       = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RST       = 6'd10;
  localparam logic [MAXFD_W-1:0] MAX_FRAC_DIGITS = 5'd30;
  localparam logic [MAXFD_W-1:0] MAXFD_RST       = 5'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAC = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;  // 'A' - 10

  // Digit value to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dd;
    dd = CHAR_W'(d);
    return (d < 6'd10) ? (CH_ZERO + dd) : (CH_ALPHA + dd);
  endfunction

endpackage

// ----- design/rrds_if.sv -----
// ---------------------------------------------------------------------------
// rrds_in_if / rrds_out_if: valid/ready channels of the digit string block
// Input carries one fixed-point value, output one character per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rrds_in_if import rrds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rrds_out_if import rrds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- design/real_to_radix_digit_string_core.sv -----
// ---------------------------------------------------------------------------
// real_to_radix_digit_string_core: fixed-point value to radix text
// Converts a signed fixed-point value into ASCII digits in a chosen radix.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  : one signed value per request (Q INTEGER_BITS . FRACTION_BITS,
//           upper bits ignored). in_i.ready is high only when the block is
//           idle; a new request is taken while the last character of the
//           previous string still waits in the output register.
//   out_o : one character per request: optional '-', integer digits MSB
//           first (or '0'), '.', fraction digits (or '0'); last marks the
//           final character.
//   cfg   : cfg_we_i/cfg_idx_i/cfg_wdata_i write radix (index 0) and the
//           fraction digit limit (index 1); write only while idle.
// Datapath: the integer digits come from a restoring divider that retires
//   one quotient bit per cycle; fraction digits take one multiply each.
//   With the default widths a string holds at most 32 integer digits
//   (radix 2) and 30 fraction digits.
// Reset: state machine idle, output empty, radix 10, limit 10 digits.
// A stalled receiver holds the output register, and the sequencer waits whenever it has a character to emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module real_to_radix_digit_string_core import rrds_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF,
  parameter int INTEGER_BITS  = INT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rrds_in_if.sink               in_i,
  rrds_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int VB   = INTEGER_BITS + FRACTION_BITS + 1;
  localparam int IW   = INTEGER_BITS + 1;
  localparam int FB   = FRACTION_BITS;
  localparam int BCW  = $clog2(IW);
  localparam int PW   = FB + RADIX_W;
  localparam logic [FB-1:0]  FracEps = FB'(((64'd1 << FB) + 64'd5000) / 64'd10000);
  localparam logic [BCW-1:0] BitTop  = BCW'(IW - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SIGN  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_IRD   = 9'b000001000,
    S_IEMIT = 9'b000010000,
    S_IZERO = 9'b000100000,
    S_DOT   = 9'b001000000,
    S_FRAC  = 9'b010000000,
    S_FZERO = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [RADIX_W-1:0] radix_q;
  logic [MAXFD_W-1:0] maxfd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RST;
      maxfd_q <= MAXFD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIX:    radix_q <= cfg_wdata_i;
        CFG_MAX_FRAC: maxfd_q <= cfg_wdata_i[MAXFD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode: sign, magnitude, clamped settings
  logic [VB-1:0]      raw, mag;
  logic               in_neg;
  logic [RADIX_W-1:0] base_clamp;
  logic [MAXFD_W-1:0] cnt_clamp;

  assign raw    = in_i.value[VB-1:0];
  assign in_neg = raw[VB-1];
  assign mag    = in_neg ? (~raw + VB'(1)) : raw;

  always_comb begin
    base_clamp = radix_q;
    if (radix_q < RADIX_MIN) base_clamp = RADIX_MIN;
    if (radix_q > RADIX_MAX) base_clamp = RADIX_MAX;
    cnt_clamp = (maxfd_q > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : maxfd_q;
  end

  // Working registers
  logic               neg_q;
  logic [RADIX_W-1:0] base_q;
  logic [MAXFD_W-1:0] cnt_q, cnt_d;
  logic [IW-1:0]      quo_q, quo_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [BCW-1:0]     bit_q, bit_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [FB-1:0]      frac_q, frac_d;

  // Shared restoring divider step: one quotient bit per cycle
  logic [RADIX_W:0]   rem_sh, rem_sub;
  logic               div_ge;
  logic [RADIX_W-1:0] rem_nx;
  logic [IW-1:0]      quo_nx;

  assign rem_sh  = {rem_q, quo_q[IW-1]};
  assign div_ge  = rem_sh >= {1'b0, base_q};
  assign rem_sub = rem_sh - {1'b0, base_q};
  assign rem_nx  = div_ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
  assign quo_nx  = {quo_q[IW-2:0], div_ge};

  // Fraction digit multiplier
  logic [PW-1:0]      prod;
  logic [RADIX_W-1:0] fdig;
  logic               frac_last;

  assign prod      = PW'(frac_q) * PW'(base_q);
  assign fdig      = prod[PW-1:FB];
  assign frac_last = (cnt_q == MAXFD_W'(1)) || (prod[FB-1:0] < FracEps);

  // Digit buffer
  logic [RADIX_W-1:0] dbuf_mem [BUF_DEPTH];
  logic               dbuf_we, dbuf_re;
  logic [RADIX_W-1:0] dbuf_rd_q;
  logic [LEN_W-1:0]   len_dec;

  assign len_dec = len_q - LEN_W'(1);

  always_ff @(posedge clk_i) begin
    if (dbuf_we) dbuf_mem[len_q[BUF_AW-1:0]] <= rem_nx;
    if (dbuf_re) dbuf_rd_q <= dbuf_mem[len_dec[BUF_AW-1:0]];
  end

  // Output register
  logic              ovalid_q;
  logic [CHAR_W-1:0] ochar_q;
  logic              olast_q;
  logic              slot_free;
  logic              emit, emit_last;
  logic [CHAR_W-1:0] emit_char;

  assign slot_free = !ovalid_q || out_o.ready;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    len_d     = len_q;
    frac_d    = frac_q;
    dbuf_we   = 1'b0;
    dbuf_re   = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = CH_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cnt_d   = cnt_clamp;
          quo_d   = mag[VB-1:FB];
          frac_d  = mag[FB-1:0];
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        if (!neg_q || slot_free) begin
          emit      = neg_q;
          emit_char = CH_MINUS;
          rem_d     = '0;
          bit_d     = BitTop;
          len_d     = '0;
          state_d   = (quo_q == '0) ? S_IZERO : S_DIV;
        end
      end
      S_DIV: begin
        quo_d = quo_nx;
        rem_d = rem_nx;
        bit_d = bit_q - BCW'(1);
        if (bit_q == '0) begin
          dbuf_we = 1'b1;
          len_d   = len_q + LEN_W'(1);
          rem_d   = '0;
          bit_d   = BitTop;
          if (quo_nx == '0 || len_q == LEN_W'(BUF_DEPTH - 1)) state_d = S_IRD;
        end
      end
      S_IRD: begin
        dbuf_re = 1'b1;
        len_d   = len_dec;
        state_d = S_IEMIT;
      end
      S_IEMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = digit_char(dbuf_rd_q);
          state_d   = (len_q == '0) ? S_DOT : S_IRD;
        end
      end
      S_IZERO: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          state_d   = S_DOT;
        end
      end
      S_DOT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CH_DOT;
          state_d   = (cnt_q == '0 || frac_q < FracEps) ? S_FZERO : S_FRAC;
        end
      end
      S_FRAC: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = digit_char(fdig);
          emit_last = frac_last;
          frac_d    = prod[FB-1:0];
          cnt_d     = cnt_q - MAXFD_W'(1);
          if (frac_last) state_d = S_IDLE;
        end
      end
      S_FZERO: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      neg_q  <= in_neg;
      base_q <= base_clamp;
    end
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    frac_q <= frac_d;
    if (emit) begin
      ochar_q <= emit_char;
      olast_q <= emit_last;
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = ochar_q;
  assign out_o.last      = olast_q;

endmodule

// ----- design/rrds_checker.sv -----
// ---------------------------------------------------------------------------
// rrds_checker: port-level checks of the radix digit string block
// Watches the channels of the top level and flags broken sequencing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "real_to_radix_digit_string_core_assert.svh"
module rrds_checker import rrds_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] char_code_i,
  input logic              last_i
);

  // Stalled output character holds
  `RRDS_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i) && $stable(last_i))

  // One request at a time: busy right after accepting
  `RRDS_ASSERT_CLK(a_busy_after_req, in_valid_i && in_ready_i |=> !in_ready_i)

  // Only sign, point and digit characters appear
  `RRDS_ASSERT_CLK(a_char_legal, out_valid_i |-> (char_code_i == CH_MINUS) || (char_code_i == CH_DOT) || ((char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE)) || ((char_code_i >= CH_A) && (char_code_i <= CH_Z)))

  // A string never ends on a sign or a point
  `RRDS_ASSERT_CLK(a_last_is_digit, out_valid_i && last_i |-> (char_code_i != CH_MINUS) && (char_code_i != CH_DOT))

endmodule

bind real_to_radix_digit_string_core rrds_checker u_rrds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .char_code_i (out_o.char_code),
  .last_i      (out_o.last)
);
